// File: hw/rtl/job_board_dispatcher_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the job board dispatcher
// Clocked property checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef JOB_BOARD_DISPATCHER_ASSERT_SVH
`define JOB_BOARD_DISPATCHER_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define JBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("jbd check failed");
// checked during reset as well
`define JBD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("jbd check failed");
`else
`define JBD_ASSERT(lbl, prop)
`define JBD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/jbd_pkg.sv
// ----------------------------------------------------------------------------
// jbd_pkg
// Codes and field widths shared by the job board dispatcher files.
// ----------------------------------------------------------------------------
package jbd_pkg;
  localparam int OP_W     = 3;
  localparam int JID_W    = 6;
  localparam int PRIO_W   = 8;
  localparam int OCC_W    = 8;
  localparam int WORK_W   = 24;
  localparam int WORKER_W = 16;
  localparam int STAT_W   = 2;
  localparam int OPEN_W   = 7;
  localparam int SST_W    = 3;

  localparam logic [OP_W-1:0] OP_POST    = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND    = 3'd1;
  localparam logic [OP_W-1:0] OP_CLAIM   = 3'd2;
  localparam logic [OP_W-1:0] OP_ADVANCE = 3'd3;
  localparam logic [OP_W-1:0] OP_CANCEL  = 3'd4;

  localparam logic [SST_W-1:0] SS_OPEN     = 3'd1;
  localparam logic [SST_W-1:0] SS_CLAIMED  = 3'd2;
  localparam logic [SST_W-1:0] SS_PROGRESS = 3'd3;
  localparam logic [SST_W-1:0] SS_DONE     = 3'd4;
  localparam logic [SST_W-1:0] SS_CANCEL   = 3'd5;

  localparam logic [STAT_W-1:0] RS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] RS_NONE    = 2'd1;
  localparam logic [STAT_W-1:0] RS_REFUSED = 2'd2;
  localparam logic [STAT_W-1:0] RS_FULL    = 2'd3;

  localparam int unsigned PRIO_SCALE = 1000;
  localparam logic [WORK_W-1:0] WORK_MAX = 24'hFFFFFF;
  localparam logic [OPEN_W-1:0] OPEN_MAX = 7'd127;
endpackage

// File: hw/rtl/jbd_req_if.sv
// ----------------------------------------------------------------------------
// jbd_req_if
// Request channel: one item per operation, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jbd_req_if #(parameter int COORD_BITS = 20);
  import jbd_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             op;
  logic [JID_W-1:0]            job_id;
  logic [PRIO_W-1:0]           priority_req;
  logic [OCC_W-1:0]            occupation;
  logic signed [COORD_BITS-1:0] loc_x;
  logic signed [COORD_BITS-1:0] loc_y;
  logic signed [COORD_BITS-1:0] loc_z;
  logic [WORK_W-1:0]           work_amount;
  logic [WORKER_W-1:0]         worker_id;

  modport source (output valid, op, job_id, priority_req, occupation, loc_x, loc_y,
                  loc_z, work_amount, worker_id, input ready);
  modport sink (input valid, op, job_id, priority_req, occupation, loc_x, loc_y,
                loc_z, work_amount, worker_id, output ready);
endinterface

// ----------------------------------------------------------------------------
// jbd_rsp_if
// Result channel: one item per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jbd_rsp_if;
  import jbd_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [JID_W-1:0]    result_id;
  logic                completed;
  logic [WORKER_W-1:0] completed_by;
  logic [OPEN_W-1:0]   open_total;

  modport source (output valid, status, result_id, completed, completed_by, open_total,
                  input ready);
  modport sink (input valid, status, result_id, completed, completed_by, open_total,
                output ready);
endinterface

// File: hw/rtl/job_board_dispatcher.sv
// ----------------------------------------------------------------------------
// job_board_dispatcher
// Job table with post, find best, claim, advance and cancel operations.
// ----------------------------------------------------------------------------
// channel  modport  direction  contents
// req      sink     in         op, job_id, priority_req, occupation, loc, work, worker
// rsp      source   out        status, result_id, completed, completed_by, open_total
//
// One item at a time; a new item is accepted only in idle.
// Post, an unknown slot and an undefined op go from idle to respond; claim/advance/cancel
// of a posted slot go through read, modify-write and respond.
// Find walks every slot through the single RAM read port, one per cycle, then
// drains the distance pipeline; the result goes to respond once it is empty.
// Slots fill in order, so a slot at or past the fill count reads as empty and
// reset needs no clearing pass. A stalled result holds the sequencer in its
// respond state; a new item is taken once it is back in idle.
// ----------------------------------------------------------------------------
module job_board_dispatcher #(
  parameter int JOBS       = 64,
  parameter int COORD_BITS = 20
) (
  input logic clk,
  input logic rst,
  jbd_req_if.sink   req,
  jbd_rsp_if.source rsp
);
  import jbd_pkg::*;
  `include "job_board_dispatcher_assert.svh"

  localparam int CB  = COORD_BITS;
  localparam int IW  = (JOBS > 1) ? $clog2(JOBS) : 1;
  localparam int CW  = $clog2(JOBS + 1);
  localparam int AW  = (IW > JID_W) ? IW : JID_W;
  localparam int WW  = ((AW > CW) ? AW : CW) + 1;
  localparam int OW  = (CW > OPEN_W) ? CW : OPEN_W;
  localparam int SW  = 2 * CB + 4;
  localparam int RW  = CB + 2;
  localparam int SCW = ((RW > 18) ? RW : 18) + 2;

  // record layout
  localparam int O_CLM  = 0;
  localparam int O_DONE = O_CLM + WORKER_W;
  localparam int O_NEED = O_DONE + WORK_W;
  localparam int O_Z    = O_NEED + WORK_W;
  localparam int O_Y    = O_Z + CB;
  localparam int O_X    = O_Y + CB;
  localparam int O_OCC  = O_X + CB;
  localparam int O_PRIO = O_OCC + OCC_W;
  localparam int O_ST   = O_PRIO + PRIO_W;
  localparam int REC_W  = O_ST + SST_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state;

  logic [CW-1:0] next_slot;
  logic [CW-1:0] open_cnt;

  // latched request
  logic [OP_W-1:0]      r_op;
  logic [IW-1:0]        r_addr;
  logic [OCC_W-1:0]     r_occ;
  logic signed [CB-1:0] r_x, r_y, r_z;
  logic [WORK_W-1:0]    r_work;
  logic [WORKER_W-1:0]  r_worker;

  // pending result
  logic [STAT_W-1:0]   res_status;
  logic [JID_W-1:0]    res_id;
  logic                res_done;
  logic [WORKER_W-1:0] res_by;

  // output register
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [JID_W-1:0]    out_id;
  logic                out_done;
  logic [WORKER_W-1:0] out_by;
  logic [OPEN_W-1:0]   out_open;

  // RAM ports
  logic             mem_we;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [REC_W-1:0] mem_wdata, rdata;

  jbd_ram #(.WIDTH(REC_W), .DEPTH(JOBS)) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  logic          accept;
  logic [AW-1:0] in_id_ext;
  logic          in_known;
  logic          table_full;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign in_id_ext  = AW'(req.job_id);
  assign in_known   = WW'(in_id_ext) < WW'(next_slot);
  assign table_full = (next_slot == CW'(JOBS));

  // read-modify-write of one slot
  logic [SST_W-1:0]    m_st;
  logic [WORK_W:0]     m_sum_raw;
  logic [WORK_W-1:0]   m_sum;
  logic                m_fin;
  logic                m_we;
  logic                m_dec;
  logic [STAT_W-1:0]   m_status;
  logic                m_done;
  logic [WORKER_W-1:0] m_by;
  logic [REC_W-1:0]    m_rec;

  always_comb begin
    m_st      = rdata[O_ST +: SST_W];
    m_sum_raw = {1'b0, rdata[O_DONE +: WORK_W]} + {1'b0, r_work};
    m_sum     = m_sum_raw[WORK_W] ? WORK_MAX : m_sum_raw[WORK_W-1:0];
    m_fin     = m_sum >= rdata[O_NEED +: WORK_W];
    m_rec     = rdata;
    m_we      = 1'b0;
    m_dec     = 1'b0;
    m_status  = RS_OK;
    m_done    = 1'b0;
    m_by      = '0;
    case (r_op)
      OP_CLAIM: begin
        if (m_st != SS_OPEN) begin
          m_status = RS_REFUSED;
        end else begin
          m_we = 1'b1;
          m_dec = 1'b1;
          m_rec[O_ST +: SST_W] = SS_CLAIMED;
          m_rec[O_CLM +: WORKER_W] = r_worker;
        end
      end
      OP_ADVANCE: begin
        if (m_st == SS_DONE) begin
          m_status = RS_REFUSED;
        end else begin
          m_we = 1'b1;
          m_dec = (m_st == SS_OPEN);
          m_rec[O_DONE +: WORK_W] = m_sum;
          m_rec[O_ST +: SST_W] = m_fin ? SS_DONE : SS_PROGRESS;
          m_done = m_fin;
          m_by = m_fin ? rdata[O_CLM +: WORKER_W] : '0;
        end
      end
      default: begin
        m_we = 1'b1;
        m_dec = (m_st == SS_OPEN);
        m_rec[O_ST +: SST_W] = SS_CANCEL;
      end
    endcase
  end

  // scan pipeline
  logic [CW-1:0] ptr;
  logic          scan_issue;
  logic          t0_v;
  logic [IW-1:0] t0_idx;

  logic          a_v;
  logic [IW-1:0] a_idx;
  logic [7:0]    a_prio;
  logic [CB:0]   a_mx, a_my, a_mz;
  logic          b_v;
  logic [IW-1:0] b_idx;
  logic [7:0]    b_prio;
  logic [2*CB+1:0] b_sx, b_sy, b_sz;

  logic [RW:0]     sq_v;
  logic [SW-1:0]   sq_n    [RW+1];
  logic [RW+2:0]   sq_rem  [RW+1];
  logic [RW-1:0]   sq_root [RW+1];
  logic [7:0]      sq_prio [RW+1];
  logic [IW-1:0]   sq_idx  [RW+1];

  logic                  have;
  logic signed [SCW-1:0] best;
  logic [IW-1:0]         best_idx;
  logic signed [SCW-1:0] score;
  logic                  pipe_busy;

  assign scan_issue = (state == ST_SCAN) && (ptr != CW'(JOBS));
  assign pipe_busy  = t0_v || a_v || b_v || (|sq_v);

  logic                  s_elig;
  logic signed [CB:0]    s_dx, s_dy, s_dz;

  always_comb begin
    s_elig = t0_v && (rdata[O_ST +: SST_W] == SS_OPEN) &&
             ((rdata[O_OCC +: OCC_W] == '0) || (rdata[O_OCC +: OCC_W] == r_occ));
    s_dx = (CB+1)'($signed(rdata[O_X +: CB])) - (CB+1)'(r_x);
    s_dy = (CB+1)'($signed(rdata[O_Y +: CB])) - (CB+1)'(r_y);
    s_dz = (CB+1)'($signed(rdata[O_Z +: CB])) - (CB+1)'(r_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v <= 1'b0;
      a_v <= 1'b0;
      b_v <= 1'b0;
      sq_v <= '0;
    end else begin
      t0_v <= scan_issue && (ptr < next_slot);
      a_v <= s_elig;
      b_v <= a_v;
      sq_v <= {sq_v[RW-1:0], b_v};
    end
    t0_idx <= ptr[IW-1:0];
    a_idx  <= t0_idx;
    a_prio <= rdata[O_PRIO +: PRIO_W];
    a_mx   <= s_dx[CB] ? -s_dx : s_dx;
    a_my   <= s_dy[CB] ? -s_dy : s_dy;
    a_mz   <= s_dz[CB] ? -s_dz : s_dz;
    b_idx  <= a_idx;
    b_prio <= a_prio;
    b_sx   <= a_mx * a_mx;
    b_sy   <= a_my * a_my;
    b_sz   <= a_mz * a_mz;
    sq_n[0]    <= SW'(b_sx) + SW'(b_sy) + SW'(b_sz);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_prio[0] <= b_prio;
    sq_idx[0]  <= b_idx;
  end

  // integer square root, one result bit per stage
  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    logic [RW+2:0] t, trial;
    logic          ge;
    always_comb begin
      t     = {sq_rem[g][RW:0], sq_n[g][SW-1:SW-2]};
      trial = (RW+3)'({sq_root[g], 2'b01});
      ge    = t >= trial;
    end
    always_ff @(posedge clk) begin
      sq_n[g+1]    <= {sq_n[g][SW-3:0], 2'b00};
      sq_rem[g+1]  <= ge ? (t - trial) : t;
      sq_root[g+1] <= {sq_root[g][RW-2:0], ge};
      sq_prio[g+1] <= sq_prio[g];
      sq_idx[g+1]  <= sq_idx[g];
    end
  end

  assign score = $signed(SCW'(sq_prio[RW]) * SCW'(PRIO_SCALE)) -
                 $signed(SCW'(sq_root[RW]));

  // RAM port muxing
  always_comb begin
    mem_raddr = (state == ST_SCAN) ? ptr[IW-1:0] : in_id_ext[IW-1:0];
    mem_we    = 1'b0;
    mem_waddr = r_addr;
    mem_wdata = m_rec;
    if (state == ST_IDLE) begin
      mem_we    = accept && (req.op == OP_POST) && !table_full;
      mem_waddr = next_slot[IW-1:0];
      mem_wdata = {SS_OPEN, req.priority_req, req.occupation, req.loc_x, req.loc_y,
                   req.loc_z, req.work_amount, {WORK_W{1'b0}}, {WORKER_W{1'b0}}};
    end else if (state == ST_MOD) begin
      mem_we = m_we;
    end
  end

  logic [AW-1:0] next_slot_ext, best_ext;
  logic [OW-1:0] open_ext;
  logic          out_free;

  assign next_slot_ext = AW'(next_slot);
  assign best_ext      = AW'(best_idx);
  assign open_ext      = OW'(open_cnt);
  assign out_free      = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_slot <= '0;
      open_cnt  <= '0;
      out_valid <= 1'b0;
      ptr       <= '0;
      have      <= 1'b0;
    end else begin
      if (state == ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_done <= 1'b0;
            res_by   <= '0;
            case (req.op)
              OP_POST: begin
                state <= ST_RESP;
                if (table_full) begin
                  res_status <= RS_FULL;
                  res_id     <= '0;
                end else begin
                  res_status <= RS_OK;
                  res_id     <= next_slot_ext[JID_W-1:0];
                  next_slot  <= next_slot + 1'b1;
                  open_cnt   <= open_cnt + 1'b1;
                end
              end
              OP_FIND: begin
                res_status <= RS_NONE;
                res_id     <= '0;
                ptr        <= '0;
                have       <= 1'b0;
                state      <= ST_SCAN;
              end
              OP_CLAIM, OP_ADVANCE, OP_CANCEL: begin
                res_status <= RS_NONE;
                res_id     <= '0;
                state      <= in_known ? ST_MOD : ST_RESP;
              end
              default: begin
                res_status <= RS_NONE;
                res_id     <= '0;
                state      <= ST_RESP;
              end
            endcase
          end
        end
        ST_MOD: begin
          res_status <= m_status;
          res_done   <= m_done;
          res_by     <= m_by;
          if (m_dec && open_cnt != '0) begin
            open_cnt <= open_cnt - 1'b1;
          end
          state <= ST_RESP;
        end
        ST_SCAN: begin
          if (scan_issue) begin
            ptr <= ptr + 1'b1;
          end
          if (sq_v[RW] && (!have || score > best)) begin
            have     <= 1'b1;
            best     <= score;
            best_idx <= sq_idx[RW];
          end
          if (!scan_issue && !pipe_busy) begin
            res_status <= have ? RS_OK : RS_NONE;
            res_id     <= have ? best_ext[JID_W-1:0] : '0;
            state      <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request and response payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      r_op     <= req.op;
      r_addr   <= in_id_ext[IW-1:0];
      r_occ    <= req.occupation;
      r_x      <= req.loc_x;
      r_y      <= req.loc_y;
      r_z      <= req.loc_z;
      r_work   <= req.work_amount;
      r_worker <= req.worker_id;
    end
    if (state == ST_RESP && out_free) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_done   <= res_done;
      out_by     <= res_by;
      out_open   <= (open_ext > OW'(OPEN_MAX)) ? OPEN_MAX : open_ext[OPEN_W-1:0];
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_id    = out_id;
  assign rsp.completed    = out_done;
  assign rsp.completed_by = out_by;
  assign rsp.open_total   = out_open;

  `JBD_ASSERT(a_open_le_fill, open_cnt <= next_slot)
  `JBD_ASSERT(a_fill_bound, next_slot <= CW'(JOBS))
  `JBD_ASSERT_ALWAYS(a_reset_idle, rst |=> state == ST_IDLE)
  `JBD_ASSERT(a_write_state, mem_we |-> (state == ST_IDLE || state == ST_MOD))
  `JBD_ASSERT(a_pipe_in_scan, pipe_busy |-> state == ST_SCAN)
  `JBD_ASSERT(a_accept_leaves_idle, accept |=> state != ST_IDLE)
endmodule

// File: hw/rtl/jbd_ram.sv
// ----------------------------------------------------------------------------
// jbd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module jbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: dv/job_board_dispatcher_tb.sv
// ----------------------------------------------------------------------------
// job_board_dispatcher_tb
// Self-checking bench for the job board: a table of directed items, then
// random post/find/claim/advance/cancel/undefined-op traffic. Each result is
// checked against a typed row or the job table model. Both sides pause at random.
// ----------------------------------------------------------------------------
module job_board_dispatcher_tb;
  import jbd_pkg::*;

  localparam int JOBS       = 64;
  localparam int COORD_BITS = 20;
  localparam int N_RANDOM   = 930;
  localparam int LIMIT      = 2000000;
  localparam int DRAIN      = 200;
  localparam int HOLD_AT    = 40;
  localparam int HOLD_LEN   = 600;

  localparam logic [SST_W-1:0] SS_EMPTY = 3'd0;

  typedef struct {
    logic [OP_W-1:0]              op;
    logic [JID_W-1:0]             job_id;
    logic [PRIO_W-1:0]            prio;
    logic [OCC_W-1:0]             occ;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [WORK_W-1:0]            work;
    logic [WORKER_W-1:0]          worker;
  } job_req_t;

  typedef struct {
    logic [STAT_W-1:0]   status;
    logic [JID_W-1:0]    rid;
    logic                done;
    logic [WORKER_W-1:0] by;
    logic [OPEN_W-1:0]   open_n;
  } job_rsp_t;

  typedef struct {
    job_req_t req;
    bit       typed;
    job_rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jbd_req_if #(.COORD_BITS(COORD_BITS)) req ();
  jbd_rsp_if rsp ();

  job_board_dispatcher #(.JOBS(JOBS), .COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // job table model
  logic [SST_W-1:0]    tbl_state  [JOBS];
  logic [PRIO_W-1:0]   tbl_prio   [JOBS];
  logic [OCC_W-1:0]    tbl_occ    [JOBS];
  longint              tbl_pos    [JOBS][3];
  logic [WORK_W-1:0]   tbl_need   [JOBS];
  logic [WORK_W-1:0]   tbl_done   [JOBS];
  logic [WORKER_W-1:0] tbl_owner  [JOBS];
  int unsigned         fill_count;
  int unsigned         open_jobs;

  job_rsp_t pending_rsp[$];
  int  errors;
  int  rx_count;
  int  n_op[8];
  int  n_found, n_completed, n_full;
  bit  hold_done;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic void drop_open(int s);
    if (tbl_state[s] == SS_OPEN && open_jobs > 0) open_jobs--;
  endfunction

  function automatic job_rsp_t board_apply(job_req_t r);
    job_rsp_t o;
    bit known, have;
    longint best, score, dx, dy, dz;
    longint unsigned sum;
    int s;
    o = '{status: RS_NONE, rid: '0, done: 1'b0, by: '0, open_n: '0};
    known = tbl_state[r.job_id] != SS_EMPTY;
    have = 0;
    best = 0;
    case (r.op)
      OP_POST: begin
        if (fill_count >= JOBS) begin
          o.status = RS_FULL;
          n_full++;
        end else begin
          s = fill_count++;
          tbl_state[s] = SS_OPEN;
          tbl_prio[s] = r.prio;
          tbl_occ[s] = r.occ;
          tbl_pos[s][0] = r.x;
          tbl_pos[s][1] = r.y;
          tbl_pos[s][2] = r.z;
          tbl_need[s] = r.work;
          tbl_done[s] = '0;
          tbl_owner[s] = '0;
          open_jobs++;
          o.status = RS_OK;
          o.rid = s;
        end
      end
      OP_FIND: begin
        for (s = 0; s < JOBS; s++) begin
          if (tbl_state[s] != SS_OPEN) continue;
          if (tbl_occ[s] != 0 && tbl_occ[s] != r.occ) continue;
          dx = tbl_pos[s][0] - longint'(r.x);
          dy = tbl_pos[s][1] - longint'(r.y);
          dz = tbl_pos[s][2] - longint'(r.z);
          score = longint'(tbl_prio[s]) * PRIO_SCALE
                - longint'(int_sqrt(dx * dx + dy * dy + dz * dz));
          if (!have || score > best) begin
            have = 1;
            best = score;
            o.rid = s;
          end
        end
        o.status = have ? RS_OK : RS_NONE;
        if (have) n_found++;
      end
      OP_CLAIM: begin
        if (!known) o.status = RS_NONE;
        else if (tbl_state[r.job_id] != SS_OPEN) o.status = RS_REFUSED;
        else begin
          drop_open(r.job_id);
          tbl_state[r.job_id] = SS_CLAIMED;
          tbl_owner[r.job_id] = r.worker;
          o.status = RS_OK;
        end
      end
      OP_ADVANCE: begin
        if (!known) o.status = RS_NONE;
        else if (tbl_state[r.job_id] == SS_DONE) o.status = RS_REFUSED;
        else begin
          sum = tbl_done[r.job_id] + r.work;
          if (sum > WORK_MAX) sum = WORK_MAX;
          drop_open(r.job_id);
          tbl_state[r.job_id] = SS_PROGRESS;
          tbl_done[r.job_id] = sum;
          if (sum >= tbl_need[r.job_id]) begin
            tbl_state[r.job_id] = SS_DONE;
            o.done = 1'b1;
            o.by = tbl_owner[r.job_id];
            n_completed++;
          end
          o.status = RS_OK;
        end
      end
      OP_CANCEL: begin
        if (!known) o.status = RS_NONE;
        else begin
          drop_open(r.job_id);
          tbl_state[r.job_id] = SS_CANCEL;
          o.status = RS_OK;
        end
      end
      default: o.status = RS_NONE;
    endcase
    o.open_n = open_jobs > 127 ? OPEN_MAX : open_jobs;
    return o;
  endfunction

  // sender: fields change at the falling edge, acceptance seen at the rising edge
  task automatic send_job(job_req_t r, bit typed, job_rsp_t typed_rsp);
    job_rsp_t p;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.op = r.op;
    req.job_id = r.job_id;
    req.priority_req = r.prio;
    req.occupation = r.occ;
    req.loc_x = r.x;
    req.loc_y = r.y;
    req.loc_z = r.z;
    req.work_amount = r.work;
    req.worker_id = r.worker;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    p = board_apply(r);
    n_op[r.op]++;
    pending_rsp.push_back(typed ? typed_rsp : p);
    @(negedge clk);
  endtask

  function automatic job_req_t rand_job();
    job_req_t r;
    int pick;
    r.op = OP_FIND;
    r.job_id = (fill_count > 0 && $urandom_range(0, 7) != 0) ?
               $urandom_range(0, fill_count - 1) : $urandom_range(0, 63);
    r.prio = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) * 100 : $urandom_range(0, 255);
    r.occ = $urandom_range(0, 2) == 0 ? 8'd0 : $urandom_range(0, 1) ? $urandom_range(1, 3)
                                                                   : $urandom_range(0, 255);
    if ($urandom_range(0, 1)) begin
      r.x = $urandom_range(0, 2 ** COORD_BITS - 1);
      r.y = $urandom_range(0, 2 ** COORD_BITS - 1);
      r.z = $urandom_range(0, 2 ** COORD_BITS - 1);
    end else begin
      r.x = $signed($urandom_range(0, 2000)) - 1000;
      r.y = $signed($urandom_range(0, 2000)) - 1000;
      r.z = $signed($urandom_range(0, 2000)) - 1000;
    end
    r.work = $urandom_range(0, 2) == 0 ? $urandom_range(0, 2 ** WORK_W - 1)
                                       : $urandom_range(0, 1023);
    r.worker = $urandom_range(0, 65535);
    pick = $urandom_range(0, 99);
    if (pick < (fill_count < JOBS ? 30 : 4)) r.op = OP_POST;
    else if (pick < 50) r.op = OP_FIND;
    else if (pick < 68) r.op = OP_CLAIM;
    else if (pick < 86) r.op = OP_ADVANCE;
    else if (pick < 96) r.op = OP_CANCEL;
    else r.op = $urandom_range(5, 7);
    return r;
  endfunction

  // receiver: ready changes at the falling edge
  initial begin
    job_rsp_t e;
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
      if (!hold_done && rx_count == HOLD_AT) begin
        stall = HOLD_LEN;
        hold_done = 1;
      end
      rsp.ready = 1'b0;
      repeat (stall) @(negedge clk);
      rsp.ready = 1'b1;
      do @(posedge clk); while (!rsp.valid);
      rx_count++;
      if (pending_rsp.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status); errors++;
        end
        if (rsp.result_id !== e.rid) begin
          $error("result_id exp %0d got %0d", e.rid, rsp.result_id); errors++;
        end
        if (rsp.completed !== e.done) begin
          $error("completed exp %0d got %0d", e.done, rsp.completed); errors++;
        end
        if (rsp.completed_by !== e.by) begin
          $error("completed_by exp %0d got %0d", e.by, rsp.completed_by); errors++;
        end
        if (rsp.open_total !== e.open_n) begin
          $error("open_total exp %0d got %0d", e.open_n, rsp.open_total); errors++;
        end
      end
      @(negedge clk);
    end
  end

  int cycles;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic job_req_t mk(logic [OP_W-1:0] op, int id, int prio, int occ,
                                  int x, int y, int z, int work, int worker);
    job_req_t r;
    r = '{op: op, job_id: id, prio: prio, occ: occ, x: x, y: y, z: z,
          work: work, worker: worker};
    return r;
  endfunction

  function automatic job_rsp_t rs(logic [STAT_W-1:0] st, int id, bit d, int by, int n);
    job_rsp_t o;
    o = '{status: st, rid: id, done: d, by: by, open_n: n};
    return o;
  endfunction

  localparam int CMAX = 2 ** (COORD_BITS - 1) - 1;
  localparam int CMIN = -(2 ** (COORD_BITS - 1));

  initial begin
    dir_row_t rows[$];
    job_rsp_t none_rsp;
    none_rsp = rs(RS_NONE, 0, 0, 0, 0);
    errors = 0;
    rx_count = 0;
    hold_done = 0;
    cycles = 0;
    fill_count = 0;
    open_jobs = 0;
    n_found = 0;
    n_completed = 0;
    n_full = 0;
    foreach (n_op[i]) n_op[i] = 0;
    foreach (tbl_state[i]) tbl_state[i] = SS_EMPTY;
    req.valid = 1'b0;
    req.op = OP_POST;
    req.job_id = '0;
    req.priority_req = '0;
    req.occupation = '0;
    req.loc_x = '0;
    req.loc_y = '0;
    req.loc_z = '0;
    req.work_amount = '0;
    req.worker_id = '0;

    // empty table, unknown slots and ops, extreme posts, claim/advance/cancel paths
    rows.push_back('{mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0), 1, none_rsp});
    rows.push_back('{mk(OP_CLAIM, 0, 0, 0, 0, 0, 0, 0, 1), 1, none_rsp});
    rows.push_back('{mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0), 1, none_rsp});
    rows.push_back('{mk(3'd7, 63, 255, 255, 0, 0, 0, 0, 0), 1, none_rsp});
    rows.push_back('{mk(OP_POST, 63, 255, 0, CMAX, CMAX, CMAX, 24'hFFFFFF, 65535), 1,
                     rs(RS_OK, 0, 0, 0, 1)});
    rows.push_back('{mk(OP_POST, 0, 0, 255, CMIN, CMIN, CMIN, 0, 0), 1,
                     rs(RS_OK, 1, 0, 0, 2)});
    rows.push_back('{mk(OP_POST, 0, 255, 0, 0, 0, 0, 5, 0), 1, rs(RS_OK, 2, 0, 0, 3)});
    rows.push_back('{mk(OP_FIND, 0, 0, 7, 0, 0, 0, 0, 0), 0, none_rsp});
    rows.push_back('{mk(OP_FIND, 0, 0, 255, CMIN, CMIN, CMIN, 0, 0), 0, none_rsp});
    rows.push_back('{mk(OP_FIND, 0, 0, 0, CMAX, CMIN, CMAX, 0, 0), 0, none_rsp});
    rows.push_back('{mk(OP_CLAIM, 1, 0, 0, 0, 0, 0, 0, 65535), 1, rs(RS_OK, 0, 0, 0, 2)});
    rows.push_back('{mk(OP_CLAIM, 1, 0, 0, 0, 0, 0, 0, 3), 1, rs(RS_REFUSED, 0, 0, 0, 2)});
    rows.push_back('{mk(OP_ADVANCE, 1, 0, 0, 0, 0, 0, 0, 0), 1,
                     rs(RS_OK, 0, 1, 65535, 2)});
    rows.push_back('{mk(OP_ADVANCE, 1, 0, 0, 0, 0, 0, 9, 0), 1, rs(RS_REFUSED, 0, 0, 0, 2)});
    rows.push_back('{mk(OP_ADVANCE, 2, 0, 0, 0, 0, 0, 2, 0), 1, rs(RS_OK, 0, 0, 0, 1)});
    rows.push_back('{mk(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0), 1,
                     rs(RS_OK, 0, 1, 0, 0)});
    rows.push_back('{mk(OP_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0), 1, rs(RS_OK, 0, 0, 0, 0)});
    // cancelled job advanced again: saturating add completes it once more
    rows.push_back('{mk(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0), 0, none_rsp});
    rows.push_back('{mk(OP_CANCEL, 2, 0, 0, 0, 0, 0, 0, 0), 1, rs(RS_OK, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0), 1, none_rsp});
    rows.push_back('{mk(OP_CLAIM, 63, 0, 0, 0, 0, 0, 0, 0), 1, none_rsp});
    rows.push_back('{mk(OP_CANCEL, 40, 0, 0, 0, 0, 0, 0, 0), 1, none_rsp});
    rows.push_back('{mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0), 1, none_rsp});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_job(rows[i].req, rows[i].typed, rows[i].rsp);
    repeat (N_RANDOM) send_job(rand_job(), 0, none_rsp);
    req.valid = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d results never arrived", pending_rsp.size());
      errors++;
    end

    $display("covered: %0d posts (%0d refused full), %0d finds (%0d hits), %0d claims,",
             n_op[OP_POST], n_full, n_op[OP_FIND], n_found, n_op[OP_CLAIM]);
    $display("  %0d advances (%0d completions), %0d cancels, %0d undefined ops, %0d results",
             n_op[OP_ADVANCE], n_completed, n_op[OP_CANCEL],
             n_op[5] + n_op[6] + n_op[7], rx_count);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
